// ===== rtl/core/tlohlc_pkg.sv =====
// Shared types, codes and defaults for the trade ledger core.
`default_nettype none
package tlohlc_pkg;

    localparam int unsigned DefNumSymbols = 64;
    localparam int unsigned DefLogDepth   = 1024;

    typedef enum logic [1:0] {
        OP_RECORD  = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_ADJUST  = 2'd2,
        OP_REPLACE = 2'd3
    } t_op;

    typedef struct packed {
        logic [5:0]  sym;
        logic [63:0] id;
        logic [31:0] price;
        logic [31:0] vol;
        logic        canc;
    } t_entry;

    typedef struct packed {
        logic        valid;
        logic [31:0] open;
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] close;
        logic [63:0] vol;
    } t_stat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOKUP,
        ST_DECIDE,
        ST_APPEND,
        ST_RDSTAT,
        ST_LOAD,
        ST_MODIFY,
        ST_RECOMP,
        ST_WRSTAT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic latch;
        logic clr_wr;
        logic lk_start;
        logic lk_step;
        logic wb_canc;
        logic wb_vol;
        logic append;
        logic fail_inc;
        logic set_full;
        logic set_ok;
        logic st_zero;
        logic st_load;
        logic st_fold;
        logic st_adj;
        logic rc_start;
        logic rc_step;
        logic st_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic in_range;
        logic full;
        logic clr_last;
        logic lk_done;
        logic found;
        logic ent_canc;
        logic rc_done;
        logic ok;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/core/trade_ledger_ohlc_with_corrections_core.sv =====
// Top level of the trade ledger with per-symbol OHLC statistics and corrections.
//
// Operations arrive on the input channel (i_in_valid / o_in_ready) as one beat each:
// record, cancel, adjust volume or replace, addressed to a symbol and a trade id.
// Every operation yields exactly one result beat on the output channel
// (o_out_valid / i_out_ready): the outcome, the symbol's OHLC and volume after the
// operation, the running failure count and the log-full flag.
// One operation is handled at a time. The lookup of a cancel, adjust or replace walks the
// log from the newest entry; a successful cancel or a replace then re-folds the symbol
// by walking all N logged entries, one read of the log memory per cycle.
// After reset the statistics memory is cleared, one symbol per cycle, and no operation
// is taken during that pass.
// A result waits in the output register while the receiver stalls; the next
// operation may be accepted and worked on meanwhile, but its result is held back
// until the pending one has been taken.
`default_nettype none
module trade_ledger_ohlc_with_corrections_core #(
    parameter int unsigned NUM_SYMBOLS = tlohlc_pkg::DefNumSymbols,
    parameter int unsigned LOG_DEPTH   = tlohlc_pkg::DefLogDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [5:0]  i_symbol_index,
    input  wire logic [63:0] i_trade_id,
    input  wire logic [63:0] i_new_trade_id,
    input  wire logic [31:0] i_price,
    input  wire logic [31:0] i_volume,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_ok,
    output logic             o_has_prices,
    output logic [31:0]      o_open_price,
    output logic [31:0]      o_high_price,
    output logic [31:0]      o_low_price,
    output logic [31:0]      o_close_price,
    output logic [63:0]      o_total_volume,
    output logic [31:0]      o_failure_count,
    output logic             o_log_full
);

    tlohlc_pkg::t_cmd w_cmd;
    tlohlc_pkg::t_sts w_sts;

    tlohlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tlohlc_dp #(.NUM_SYMBOLS(NUM_SYMBOLS), .LOG_DEPTH(LOG_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_opcode        (i_opcode),
        .i_symbol_index  (i_symbol_index),
        .i_trade_id      (i_trade_id),
        .i_new_trade_id  (i_new_trade_id),
        .i_price         (i_price),
        .i_volume        (i_volume),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_has_prices    (o_has_prices),
        .o_open_price    (o_open_price),
        .o_high_price    (o_high_price),
        .o_low_price     (o_low_price),
        .o_close_price   (o_close_price),
        .o_total_volume  (o_total_volume),
        .o_failure_count (o_failure_count),
        .o_log_full      (o_log_full)
    );

endmodule
`default_nettype wire

// ===== rtl/core/tlohlc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tlohlc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/tlohlc_ctrl.sv =====
// Controller state machine that sequences each ledger operation.
`default_nettype none
module tlohlc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tlohlc_pkg::t_sts   i_sts,
    output tlohlc_pkg::t_cmd        o_cmd
);

    tlohlc_pkg::t_state r_state;
    tlohlc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlohlc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlohlc_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = tlohlc_pkg::ST_IDLE;
            end
            tlohlc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tlohlc_pkg::ST_DISPATCH;
            end
            tlohlc_pkg::ST_DISPATCH: begin
                if (!i_sts.in_range) begin
                    n_state = tlohlc_pkg::ST_OUT;
                end else if (i_sts.op == tlohlc_pkg::OP_RECORD) begin
                    n_state = tlohlc_pkg::ST_RDSTAT;
                end else begin
                    n_state = tlohlc_pkg::ST_LOOKUP;
                end
            end
            tlohlc_pkg::ST_LOOKUP: begin
                if (i_sts.lk_done) n_state = tlohlc_pkg::ST_DECIDE;
            end
            tlohlc_pkg::ST_DECIDE: begin
                case (i_sts.op)
                    tlohlc_pkg::OP_CANCEL: begin
                        if (i_sts.found && !i_sts.ent_canc) n_state = tlohlc_pkg::ST_RECOMP;
                        else n_state = tlohlc_pkg::ST_RDSTAT;
                    end
                    tlohlc_pkg::OP_REPLACE: n_state = tlohlc_pkg::ST_APPEND;
                    default: n_state = tlohlc_pkg::ST_RDSTAT;
                endcase
            end
            tlohlc_pkg::ST_APPEND:  n_state = tlohlc_pkg::ST_RECOMP;
            tlohlc_pkg::ST_RDSTAT:  n_state = tlohlc_pkg::ST_LOAD;
            tlohlc_pkg::ST_LOAD:    n_state = tlohlc_pkg::ST_MODIFY;
            tlohlc_pkg::ST_MODIFY:  n_state = tlohlc_pkg::ST_WRSTAT;
            tlohlc_pkg::ST_RECOMP: begin
                if (i_sts.rc_done) n_state = tlohlc_pkg::ST_WRSTAT;
            end
            tlohlc_pkg::ST_WRSTAT:  n_state = tlohlc_pkg::ST_OUT;
            tlohlc_pkg::ST_OUT: begin
                if (i_sts.out_free) n_state = tlohlc_pkg::ST_IDLE;
            end
            default: n_state = tlohlc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tlohlc_pkg::ST_CLEAR: o_cmd.clr_wr = 1'b1;
            tlohlc_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            tlohlc_pkg::ST_DISPATCH: begin
                if (!i_sts.in_range) begin
                    o_cmd.fail_inc = 1'b1;
                    o_cmd.st_zero  = 1'b1;
                end else if (i_sts.op == tlohlc_pkg::OP_RECORD) begin
                    if (i_sts.full) begin
                        o_cmd.fail_inc = 1'b1;
                        o_cmd.set_full = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                        o_cmd.set_ok = 1'b1;
                    end
                end else begin
                    o_cmd.lk_start = 1'b1;
                end
            end
            tlohlc_pkg::ST_LOOKUP: o_cmd.lk_step = !i_sts.lk_done;
            tlohlc_pkg::ST_DECIDE: begin
                case (i_sts.op)
                    tlohlc_pkg::OP_ADJUST: begin
                        if (i_sts.found) begin
                            o_cmd.wb_vol = 1'b1;
                            o_cmd.set_ok = 1'b1;
                        end else begin
                            o_cmd.fail_inc = 1'b1;
                        end
                    end
                    default: begin
                        if (i_sts.found && !i_sts.ent_canc) begin
                            o_cmd.wb_canc  = 1'b1;
                            o_cmd.set_ok   = 1'b1;
                            o_cmd.rc_start = (i_sts.op == tlohlc_pkg::OP_CANCEL);
                        end else begin
                            o_cmd.fail_inc = 1'b1;
                        end
                    end
                endcase
            end
            tlohlc_pkg::ST_APPEND: begin
                o_cmd.rc_start = 1'b1;
                if (i_sts.full) begin
                    o_cmd.fail_inc = 1'b1;
                    o_cmd.set_full = 1'b1;
                end else begin
                    o_cmd.append = 1'b1;
                end
            end
            tlohlc_pkg::ST_LOAD: o_cmd.st_load = 1'b1;
            tlohlc_pkg::ST_MODIFY: begin
                o_cmd.st_fold = (i_sts.op == tlohlc_pkg::OP_RECORD) && i_sts.ok;
                o_cmd.st_adj  = (i_sts.op == tlohlc_pkg::OP_ADJUST) && i_sts.ok;
            end
            tlohlc_pkg::ST_RECOMP: o_cmd.rc_step = !i_sts.rc_done;
            tlohlc_pkg::ST_WRSTAT: o_cmd.st_wr = 1'b1;
            tlohlc_pkg::ST_OUT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/tlohlc_dp.sv =====
// Datapath holding the trade log, the statistics store and the result register.
`default_nettype none
module tlohlc_dp #(
    parameter int unsigned NUM_SYMBOLS = tlohlc_pkg::DefNumSymbols,
    parameter int unsigned LOG_DEPTH   = tlohlc_pkg::DefLogDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tlohlc_pkg::t_cmd  i_cmd,
    output tlohlc_pkg::t_sts       o_sts,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [5:0]        i_symbol_index,
    input  wire logic [63:0]       i_trade_id,
    input  wire logic [63:0]       i_new_trade_id,
    input  wire logic [31:0]       i_price,
    input  wire logic [31:0]       i_volume,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_ok,
    output logic                   o_has_prices,
    output logic [31:0]            o_open_price,
    output logic [31:0]            o_high_price,
    output logic [31:0]            o_low_price,
    output logic [31:0]            o_close_price,
    output logic [63:0]            o_total_volume,
    output logic [31:0]            o_failure_count,
    output logic                   o_log_full
);

    localparam int unsigned AW  = $clog2(LOG_DEPTH);
    localparam int unsigned CW  = $clog2(LOG_DEPTH + 1);
    localparam int unsigned SW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int unsigned EW  = $bits(tlohlc_pkg::t_entry);
    localparam int unsigned TW  = $bits(tlohlc_pkg::t_stat);

    tlohlc_pkg::t_op    r_op;
    logic [5:0]         r_sym;
    logic [63:0]        r_id;
    logic [63:0]        r_nid;
    logic [31:0]        r_price;
    logic [31:0]        r_vol;
    logic               r_ok;
    logic               r_full;
    logic [31:0]        r_fail;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic               r_pend;
    logic [AW-1:0]      r_pidx;
    logic               r_found;
    logic [AW-1:0]      r_idx;
    tlohlc_pkg::t_entry r_ent;
    tlohlc_pkg::t_stat  r_st;
    logic [SW-1:0]      r_clr;
    logic               r_ov;

    tlohlc_pkg::t_entry w_rd;
    tlohlc_pkg::t_entry w_wdata;
    tlohlc_pkg::t_stat  w_srd;
    tlohlc_pkg::t_stat  w_swdata;
    logic [EW-1:0]      w_rd_bits;
    logic [TW-1:0]      w_srd_bits;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [CW-1:0]      w_dec;
    logic [SW-1:0]      w_saddr;
    logic [SW-1:0]      w_swaddr;
    logic               w_swe;
    logic               w_match;
    logic               w_live_mine;

    function automatic tlohlc_pkg::t_stat fold(tlohlc_pkg::t_stat s, logic [31:0] p,
                                               logic [31:0] v);
        tlohlc_pkg::t_stat r;
        r = s;
        if (!s.valid) begin
            r.valid = 1'b1;
            r.open  = p;
            r.high  = p;
            r.low   = p;
        end else begin
            if (p > s.high) r.high = p;
            if (p < s.low) r.low = p;
        end
        r.close = p;
        r.vol   = s.vol + {32'd0, v};
        return r;
    endfunction

    assign w_rd        = tlohlc_pkg::t_entry'(w_rd_bits);
    assign w_srd       = tlohlc_pkg::t_stat'(w_srd_bits);
    assign w_dec       = r_ptr - 1'b1;
    assign w_saddr     = SW'(r_sym);
    assign w_match     = (w_rd.sym == r_sym) && (w_rd.id == r_id);
    assign w_live_mine = (w_rd.sym == r_sym) && !w_rd.canc;
    assign w_raddr     = i_cmd.lk_step ? w_dec[AW-1:0] : r_ptr[AW-1:0];

    always_comb begin
        w_we    = i_cmd.append || i_cmd.wb_canc || i_cmd.wb_vol;
        w_waddr = r_idx;
        w_wdata = r_ent;
        if (i_cmd.append) begin
            w_waddr       = r_count[AW-1:0];
            w_wdata.sym   = r_sym;
            w_wdata.id    = (r_op == tlohlc_pkg::OP_REPLACE) ? r_nid : r_id;
            w_wdata.price = r_price;
            w_wdata.vol   = r_vol;
            w_wdata.canc  = 1'b0;
        end else if (i_cmd.wb_canc) begin
            w_wdata.canc = 1'b1;
        end else begin
            w_wdata.vol = r_vol;
        end
    end

    assign w_swe    = i_cmd.clr_wr || i_cmd.st_wr;
    assign w_swaddr = i_cmd.clr_wr ? r_clr : w_saddr;
    assign w_swdata = i_cmd.clr_wr ? '0 : r_st;

    tlohlc_ram #(.WIDTH(EW), .DEPTH(LOG_DEPTH)) u_log (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_bits)
    );

    tlohlc_ram #(.WIDTH(TW), .DEPTH(NUM_SYMBOLS)) u_stat (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (w_swaddr),
        .i_wdata (w_swdata),
        .i_raddr (w_saddr),
        .o_rdata (w_srd_bits)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= tlohlc_pkg::t_op'(i_opcode);
            r_sym   <= i_symbol_index;
            r_id    <= i_trade_id;
            r_nid   <= i_new_trade_id;
            r_price <= i_price;
            r_vol   <= i_volume;
        end
        if (i_cmd.lk_start) begin
            r_ptr <= r_count;
        end else if (i_cmd.rc_start) begin
            r_ptr <= '0;
        end else if (i_cmd.lk_step) begin
            if (r_pend && w_match) begin
                r_ent <= w_rd;
                r_idx <= r_pidx;
            end else if (r_ptr != '0) begin
                r_ptr  <= w_dec;
                r_pidx <= w_dec[AW-1:0];
            end
        end else if (i_cmd.rc_step) begin
            if (r_ptr < r_count) r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.st_zero || i_cmd.rc_start) begin
            r_st <= '0;
        end else if (i_cmd.st_load) begin
            r_st <= w_srd;
        end else if (i_cmd.st_fold) begin
            r_st <= fold(r_st, r_price, r_vol);
        end else if (i_cmd.st_adj) begin
            if (!r_ent.canc) r_st.vol <= r_st.vol - {32'd0, r_ent.vol} + {32'd0, r_vol};
        end else if (i_cmd.rc_step && r_pend && w_live_mine) begin
            r_st <= fold(r_st, w_rd.price, w_rd.vol);
        end
        if (i_cmd.out_load) begin
            o_ok            <= r_ok;
            o_has_prices    <= r_st.valid;
            o_open_price    <= r_st.open;
            o_high_price    <= r_st.high;
            o_low_price     <= r_st.low;
            o_close_price   <= r_st.close;
            o_total_volume  <= r_st.vol;
            o_failure_count <= r_fail;
            o_log_full      <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok    <= 1'b0;
            r_full  <= 1'b0;
            r_fail  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_ok   <= 1'b0;
                r_full <= 1'b0;
            end else if (i_cmd.set_full) begin
                r_ok   <= 1'b0;
                r_full <= 1'b1;
            end else if (i_cmd.set_ok) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.fail_inc) r_fail <= r_fail + 1'b1;
            if (i_cmd.append) r_count <= r_count + 1'b1;
            if (i_cmd.clr_wr) r_clr <= r_clr + 1'b1;
            if (i_cmd.lk_start || i_cmd.rc_start) begin
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.lk_step) begin
                if (r_pend && w_match) begin
                    r_found <= 1'b1;
                    r_pend  <= 1'b0;
                end else begin
                    r_pend <= (r_ptr != '0);
                end
            end else if (i_cmd.rc_step) begin
                r_pend <= (r_ptr < r_count);
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_sts.op       = r_op;
    assign o_sts.in_range = (11'(r_sym) < 11'(NUM_SYMBOLS));
    assign o_sts.full     = (r_count >= CW'(LOG_DEPTH));
    assign o_sts.clr_last = (r_clr == SW'(NUM_SYMBOLS - 1));
    assign o_sts.lk_done  = r_found || ((r_ptr == '0) && !r_pend);
    assign o_sts.found    = r_found;
    assign o_sts.ent_canc = r_ent.canc;
    assign o_sts.rc_done  = (r_ptr == r_count) && !r_pend;
    assign o_sts.ok       = r_ok;
    assign o_sts.out_free = !r_ov || i_out_ready;

    a_no_append_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_count < CW'(LOG_DEPTH)))
        else $error("append issued into a full log");

    a_found_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wb_canc || i_cmd.wb_vol) |-> (r_found && (CW'(r_idx) < r_count)))
        else $error("write-back to an entry that was not found");

    a_result_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !i_cmd.out_load)
        else $error("result overwritten while still pending");

endmodule
`default_nettype wire

// ===== tb/trade_ledger_ohlc_with_corrections_core_tb.sv =====
// Self-checking testbench for the trade ledger OHLC core with cancel and correction operations.
`timescale 1ns / 100ps
module trade_ledger_ohlc_with_corrections_core_tb;

    localparam int NSYM      = 64;
    localparam int DEPTH     = 1024;
    localparam int STALL_MAX = 20000;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        tlohlc_pkg::t_op op;
        bit [5:0]    sym;
        bit [63:0]   id;
        bit [63:0]   nid;
        bit [31:0]   price;
        bit [31:0]   vol;
    } trade_op_t;

    typedef struct {
        bit          ok;
        bit          has;
        bit [31:0]   open_p;
        bit [31:0]   high_p;
        bit [31:0]   low_p;
        bit [31:0]   close_p;
        bit [63:0]   total;
        bit [31:0]   fails;
        bit          full;
    } ledger_result_t;

    class ledger_scoreboard;
        bit [5:0]       e_sym[DEPTH];
        bit [63:0]      e_id[DEPTH];
        bit [31:0]      e_price[DEPTH];
        bit [31:0]      e_vol[DEPTH];
        bit             e_canc[DEPTH];
        int             n_entries;
        bit             s_valid[NSYM];
        bit [31:0]      s_open[NSYM];
        bit [31:0]      s_high[NSYM];
        bit [31:0]      s_low[NSYM];
        bit [31:0]      s_close[NSYM];
        bit [63:0]      s_vol[NSYM];
        bit [31:0]      fail_total;
        ledger_result_t pending[$];
        int             errors;

        function void fold(int s, bit [31:0] p, bit [31:0] v);
            if (!s_valid[s]) begin
                s_valid[s] = 1;
                s_open[s] = p;
                s_high[s] = p;
                s_low[s] = p;
            end
            if (p > s_high[s]) s_high[s] = p;
            if (p < s_low[s]) s_low[s] = p;
            s_close[s] = p;
            s_vol[s] += 64'(v);
        endfunction

        function void refold(int s);
            s_valid[s] = 0;
            s_open[s] = 0;
            s_high[s] = 0;
            s_low[s] = 0;
            s_close[s] = 0;
            s_vol[s] = 0;
            for (int i = 0; i < n_entries; i++)
                if (e_sym[i] == s && !e_canc[i]) fold(s, e_price[i], e_vol[i]);
        endfunction

        function int find_newest(int s, bit [63:0] id);
            for (int i = n_entries - 1; i >= 0; i--)
                if (e_sym[i] == s && e_id[i] == id) return i;
            return -1;
        endfunction

        function bit push_entry(int s, bit [63:0] id, bit [31:0] p, bit [31:0] v);
            if (n_entries >= DEPTH) return 0;
            e_sym[n_entries] = 6'(s);
            e_id[n_entries] = id;
            e_price[n_entries] = p;
            e_vol[n_entries] = v;
            e_canc[n_entries] = 0;
            n_entries++;
            return 1;
        endfunction

        function void note_input(trade_op_t t);
            ledger_result_t r;
            int s;
            int k;
            s = t.sym;
            r.ok = 0;
            r.full = 0;
            case (t.op)
                tlohlc_pkg::OP_RECORD: begin
                    if (push_entry(s, t.id, t.price, t.vol)) begin
                        fold(s, t.price, t.vol);
                        r.ok = 1;
                    end else begin
                        r.full = 1;
                        fail_total++;
                    end
                end
                tlohlc_pkg::OP_CANCEL: begin
                    k = find_newest(s, t.id);
                    if (k < 0 || e_canc[k]) fail_total++;
                    else begin
                        e_canc[k] = 1;
                        refold(s);
                        r.ok = 1;
                    end
                end
                tlohlc_pkg::OP_ADJUST: begin
                    k = find_newest(s, t.id);
                    if (k < 0) fail_total++;
                    else begin
                        if (!e_canc[k]) s_vol[s] = s_vol[s] - 64'(e_vol[k]) + 64'(t.vol);
                        e_vol[k] = t.vol;
                        r.ok = 1;
                    end
                end
                default: begin
                    k = find_newest(s, t.id);
                    if (k >= 0 && !e_canc[k]) begin
                        e_canc[k] = 1;
                        r.ok = 1;
                    end else fail_total++;
                    if (!push_entry(s, t.nid, t.price, t.vol)) begin
                        r.full = 1;
                        r.ok = 0;
                        fail_total++;
                    end
                    refold(s);
                end
            endcase
            r.has = s_valid[s];
            r.open_p = s_open[s];
            r.high_p = s_high[s];
            r.low_p = s_low[s];
            r.close_p = s_close[s];
            r.total = s_vol[s];
            r.fails = fail_total;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(ledger_result_t a);
            ledger_result_t x;
            if (pending.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (a.ok !== x.ok) begin
                $error("ok: expected %0d, got %0d", x.ok, a.ok);
                errors++;
            end
            if (a.has !== x.has) begin
                $error("has_prices: expected %0d, got %0d", x.has, a.has);
                errors++;
            end
            if (a.open_p !== x.open_p) begin
                $error("open_price: expected %0h, got %0h", x.open_p, a.open_p);
                errors++;
            end
            if (a.high_p !== x.high_p) begin
                $error("high_price: expected %0h, got %0h", x.high_p, a.high_p);
                errors++;
            end
            if (a.low_p !== x.low_p) begin
                $error("low_price: expected %0h, got %0h", x.low_p, a.low_p);
                errors++;
            end
            if (a.close_p !== x.close_p) begin
                $error("close_price: expected %0h, got %0h", x.close_p, a.close_p);
                errors++;
            end
            if (a.total !== x.total) begin
                $error("total_volume: expected %0h, got %0h", x.total, a.total);
                errors++;
            end
            if (a.fails !== x.fails) begin
                $error("failure_count: expected %0d, got %0d", x.fails, a.fails);
                errors++;
            end
            if (a.full !== x.full) begin
                $error("log_full: expected %0d, got %0d", x.full, a.full);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic [1:0]  i_opcode = '0;
    logic [5:0]  i_symbol_index = '0;
    logic [63:0] i_trade_id = '0;
    logic [63:0] i_new_trade_id = '0;
    logic [31:0] i_price = '0;
    logic [31:0] i_volume = '0;
    logic        i_out_ready = 0;
    logic        o_in_ready, o_out_valid, o_ok, o_has_prices, o_log_full;
    logic [31:0] o_open_price, o_high_price, o_low_price, o_close_price, o_failure_count;
    logic [63:0] o_total_volume;

    ledger_scoreboard sb = new();
    bit               quiet = 0;
    bit               hold_req = 0;
    int               stall_cycles = 0;
    bit [5:0]         pool_sym[$];
    bit [63:0]        pool_id[$];

    trade_ledger_ohlc_with_corrections_core DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Receiver: random stalls, one long hold-off on request, none in the quiet tail.
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                i_out_ready <= 0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 0;
            end else begin
                n = $urandom_range(1, 10);
                i_out_ready <= quiet || ($urandom_range(0, 2) != 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_ok, o_has_prices, o_open_price, o_high_price, o_low_price,
                              o_close_price, o_total_volume, o_failure_count, o_log_full});
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_op(trade_op_t t);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_opcode <= t.op;
        i_symbol_index <= t.sym;
        i_trade_id <= t.id;
        i_new_trade_id <= t.nid;
        i_price <= t.price;
        i_volume <= t.vol;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_input(t);
        if (t.op == tlohlc_pkg::OP_RECORD || t.op == tlohlc_pkg::OP_REPLACE) begin
            pool_sym.insert(pool_sym.size(), t.sym);
            pool_id.insert(pool_id.size(), t.op == tlohlc_pkg::OP_RECORD ? t.id : t.nid);
        end
    endtask

    task automatic send_fields(tlohlc_pkg::t_op op, bit [5:0] s, bit [63:0] id,
                               bit [63:0] nid, bit [31:0] p, bit [31:0] v);
        trade_op_t t;
        t = '{op, s, id, nid, p, v};
        send_op(t);
    endtask

    function automatic bit [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic trade_op_t random_op();
        trade_op_t t;
        int k;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) t.op = tlohlc_pkg::OP_RECORD;
        else if (pick < 55) t.op = tlohlc_pkg::OP_CANCEL;
        else if (pick < 75) t.op = tlohlc_pkg::OP_ADJUST;
        else t.op = tlohlc_pkg::OP_REPLACE;
        t.sym = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
        t.id = {$urandom, $urandom};
        t.nid = {$urandom, $urandom};
        t.price = rand_word();
        t.vol = rand_word();
        if (pool_id.size() > 0 &&
            $urandom_range(0, 9) < (t.op == tlohlc_pkg::OP_RECORD ? 2 : 8)) begin
            k = $urandom_range(0, pool_id.size() - 1);
            t.sym = pool_sym[k];
            t.id = pool_id[k];
        end
        return t;
    endfunction

    initial begin
        trade_op_t t;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_fields(tlohlc_pkg::OP_RECORD, 0, 64'h0, 64'h0, 32'h0, 32'h0);
        send_fields(tlohlc_pkg::OP_RECORD, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF);
        send_fields(tlohlc_pkg::OP_RECORD, 0, 64'h5, 64'h0, 32'h1234_5678, 32'd100);
        send_fields(tlohlc_pkg::OP_RECORD, 63, 64'h5, 64'hFFFF_FFFF_FFFF_FFFF, 32'd50, 32'd7);
        send_fields(tlohlc_pkg::OP_RECORD, 0, 64'h5, 64'h0, 32'd900, 32'd3);
        send_fields(tlohlc_pkg::OP_CANCEL, 0, 64'h5, 64'h0, 32'h0, 32'h0);
        send_fields(tlohlc_pkg::OP_CANCEL, 0, 64'h5, 64'h0, 32'h0, 32'h0);
        send_fields(tlohlc_pkg::OP_CANCEL, 0, 64'hDEAD, 64'h0, 32'h0, 32'h0);
        send_fields(tlohlc_pkg::OP_ADJUST, 0, 64'h0, 64'h0, 32'h0, 32'hFFFF_FFFF);
        send_fields(tlohlc_pkg::OP_ADJUST, 0, 64'h5, 64'h0, 32'h0, 32'd77);
        send_fields(tlohlc_pkg::OP_ADJUST, 1, 64'h5, 64'h0, 32'h0, 32'd1);
        send_fields(tlohlc_pkg::OP_REPLACE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h9, 32'd10, 32'd20);
        send_fields(tlohlc_pkg::OP_REPLACE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA, 32'd11, 32'd21);
        send_fields(tlohlc_pkg::OP_REPLACE, 2, 64'h1, 64'h2, 32'd5, 32'd6);
        send_fields(tlohlc_pkg::OP_CANCEL, 63, 64'h5, 64'h0, 32'h0, 32'h0);
        send_fields(tlohlc_pkg::OP_ADJUST, 63, 64'h5, 64'h0, 32'h0, 32'd9);
        send_fields(tlohlc_pkg::OP_CANCEL, 0, 64'h0, 64'h0, 32'h0, 32'h0);
        send_fields(tlohlc_pkg::OP_CANCEL, 0, 64'h9, 64'h0, 32'h0, 32'h0);
        send_fields(tlohlc_pkg::OP_CANCEL, 0, 64'hA, 64'h0, 32'h0, 32'h0);

        for (int i = 0; i < 260; i++) begin
            if (i == 100) hold_req = 1;
            if (i == 230) quiet = 1;
            t = random_op();
            send_op(t);
        end

        send_fields(tlohlc_pkg::OP_RECORD, 3, 64'h77, 64'h0, 32'd1, 32'd1);
        send_fields(tlohlc_pkg::OP_REPLACE, pool_sym[0], pool_id[0], 64'h78, 32'd2, 32'd2);
        send_fields(tlohlc_pkg::OP_REPLACE, 4, 64'hBAD, 64'h79, 32'd3, 32'd3);
        for (int i = 0; i < 8; i++) begin
            t = random_op();
            send_op(t);
        end
        i_in_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
